// ----- rtl/core/hsv_pkg.sv -----
// hsv_pkg: shared types and constants of the hsv to rgb converter
`default_nettype none

package hsv_pkg;

  // one input word: hue in degrees, saturation and value bytes
  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_in_t;

  // one output word: rounded rgb bytes
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsv_out_t;

  // sixty degree hue sectors
  typedef enum logic [2:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYAN = 3'd2,
    SECT_CYAN_BLU = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5
  } hsv_sect_e;

  // stage enables of the scaling pipe
  typedef struct packed {
    logic mul;
    logic div;
    logic fix;
  } hsv_scl_en_t;

  localparam int unsigned HueTurn   = 360;
  localparam int unsigned HueSector = 60;
  localparam int unsigned ChanMax   = 255;
  localparam int unsigned Denom     = ChanMax * HueSector;    // 15300
  localparam int unsigned DenomHalf = Denom / 2;

  // floor(2^24 / 360), quotient off by at most one for 16-bit hue
  localparam int unsigned HueRecipShift = 24;
  localparam logic [15:0] HueRecip = 16'd46603;

  // floor(2^36 / 15300), quotient off by at most one for 22-bit numerator
  localparam int unsigned DivRecipShift = 36;
  localparam logic [22:0] DivRecip = 23'd4491469;

endpackage

`default_nettype wire

// ----- rtl/core/hsv_scale.sv -----
// hsv_scale: brightness times factor over 15300, rounded to nearest, three stages
`default_nettype none

module hsv_scale (
  input  wire logic                clk_i,
  input  wire hsv_pkg::hsv_scl_en_t en_i,
  input  wire logic [7:0]          val_i,
  input  wire logic [13:0]         fac_i,
  output logic [7:0]               chan_o
);
  import hsv_pkg::*;

  logic [21:0] num_d, num_q, num2_q;
  logic [44:0] prod_d, prod_q;
  logic [7:0]  qest;
  logic [21:0] rem;
  logic [7:0]  chan_d, chan_q;

  // numerator with half the denominator added for round to nearest
  assign num_d  = 22'(val_i) * 22'(fac_i) + 22'(DenomHalf);
  assign prod_d = 45'(num_q) * 45'(DivRecip);

  // estimate may be one low, fix with a single compare
  assign qest = prod_q[DivRecipShift +: 8];
  assign rem  = num2_q - 22'(qest) * 22'(Denom);
  assign chan_d = (rem >= 22'(Denom)) ? qest + 8'd1 : qest;

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      num_q <= num_d;
    end
    if (en_i.div) begin
      num2_q <= num_q;
      prod_q <= prod_d;
    end
    if (en_i.fix) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

// ----- rtl/core/hsv_to_rgb_converter.sv -----
// hsv_to_rgb_converter: pipelined hsv to rgb pixel converter, top level
`default_nettype none

// Converts one pixel per clock while the output is not stalled; the seven
// register stages are hue reduction (reciprocal multiply, then correction),
// sector split, factor forming, and a three-stage brightness scaling and
// divide by 15300 done as a reciprocal multiply with one correction step.
// Each stage advances when it is empty or its successor advances, so bubbles
// are squeezed out and the input only stalls while every stage holds a word
// and the output is stalled.

module hsv_to_rgb_converter (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire hsv_pkg::hsv_in_t in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output hsv_pkg::hsv_out_t     out_data_o,
  input  wire logic             out_stall_i
);
  import hsv_pkg::*;

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0] vld_q, vld_d, en;

  // stage 0: hue quotient estimate
  logic [31:0] hmul;
  logic [7:0]  hq0_d, hq0_q;
  logic [15:0] hue0_q;
  logic [7:0]  sat0_q, val0_q;
  // stage 1: hue mod 360
  logic [15:0] hdiff;
  logic [8:0]  h1_d, h1_q;
  logic [7:0]  sat1_q, val1_q;
  // stage 2: sector and remainder
  hsv_sect_e   sect2_d, sect2_q;
  logic [8:0]  base2;
  logic [5:0]  rem2_d, rem2_q;
  logic [7:0]  sat2_q, val2_q;
  // stage 3: factors
  logic [13:0] fp3_d, fq3_d, ft3_d, fp3_q, fq3_q, ft3_q;
  logic [5:0]  crem3;
  logic [7:0]  val3_q;
  hsv_sect_e   sect3_q, sect4_q, sect5_q, sect6_q;

  hsv_scl_en_t scl_en;
  logic [7:0]  pp, qq, tt, vv4_q, vv5_q, vv6_q;

  // stage enables, last stage first
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NumStages-1];

  // stage 0
  assign hmul  = 32'(in_data_i.hue) * 32'(HueRecip);
  assign hq0_d = hmul[HueRecipShift +: 8];

  // stage 1
  assign hdiff = hue0_q - 16'(hq0_q) * 16'(HueTurn);
  always_comb begin
    if (hdiff >= 16'(HueTurn)) begin
      h1_d = 9'(hdiff - 16'(HueTurn));
    end else begin
      h1_d = hdiff[8:0];
    end
  end

  // stage 2
  always_comb begin
    priority if (h1_q >= 9'd300) begin
      sect2_d = SECT_MAG_RED;
      base2   = 9'd300;
    end else if (h1_q >= 9'd240) begin
      sect2_d = SECT_BLU_MAG;
      base2   = 9'd240;
    end else if (h1_q >= 9'd180) begin
      sect2_d = SECT_CYAN_BLU;
      base2   = 9'd180;
    end else if (h1_q >= 9'd120) begin
      sect2_d = SECT_GRN_CYAN;
      base2   = 9'd120;
    end else if (h1_q >= 9'd60) begin
      sect2_d = SECT_YEL_GRN;
      base2   = 9'd60;
    end else begin
      sect2_d = SECT_RED_YEL;
      base2   = 9'd0;
    end
  end
  assign rem2_d = 6'(h1_q - base2);

  // stage 3
  assign crem3 = 6'(HueSector) - rem2_q;
  assign fp3_d = 14'(Denom) - 14'(sat2_q) * 14'(HueSector);
  assign fq3_d = 14'(Denom) - 14'(sat2_q) * 14'(rem2_q);
  assign ft3_d = 14'(Denom) - 14'(sat2_q) * 14'(crem3);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hq0_q  <= hq0_d;
      hue0_q <= in_data_i.hue;
      sat0_q <= in_data_i.saturation;
      val0_q <= in_data_i.brightness;
    end
    if (en[1]) begin
      h1_q   <= h1_d;
      sat1_q <= sat0_q;
      val1_q <= val0_q;
    end
    if (en[2]) begin
      sect2_q <= sect2_d;
      rem2_q  <= rem2_d;
      sat2_q  <= sat1_q;
      val2_q  <= val1_q;
    end
    if (en[3]) begin
      fp3_q   <= fp3_d;
      fq3_q   <= fq3_d;
      ft3_q   <= ft3_d;
      val3_q  <= val2_q;
      sect3_q <= sect2_q;
    end
    if (en[4]) begin
      sect4_q <= sect3_q;
      vv4_q   <= val3_q;
    end
    if (en[5]) begin
      sect5_q <= sect4_q;
      vv5_q   <= vv4_q;
    end
    if (en[6]) begin
      sect6_q <= sect5_q;
      vv6_q   <= vv5_q;
    end
  end

  assign scl_en = '{mul: en[4], div: en[5], fix: en[6]};

  hsv_scale u_scale_p (
    .clk_i  (clk_i),
    .en_i   (scl_en),
    .val_i  (val3_q),
    .fac_i  (fp3_q),
    .chan_o (pp)
  );

  hsv_scale u_scale_q (
    .clk_i  (clk_i),
    .en_i   (scl_en),
    .val_i  (val3_q),
    .fac_i  (fq3_q),
    .chan_o (qq)
  );

  hsv_scale u_scale_t (
    .clk_i  (clk_i),
    .en_i   (scl_en),
    .val_i  (val3_q),
    .fac_i  (ft3_q),
    .chan_o (tt)
  );

  // channel order by sector
  always_comb begin
    case (sect6_q)
      SECT_RED_YEL:  out_data_o = '{red: vv6_q, green: tt,    blue: pp};
      SECT_YEL_GRN:  out_data_o = '{red: qq,    green: vv6_q, blue: pp};
      SECT_GRN_CYAN: out_data_o = '{red: pp,    green: vv6_q, blue: tt};
      SECT_CYAN_BLU: out_data_o = '{red: pp,    green: qq,    blue: vv6_q};
      SECT_BLU_MAG:  out_data_o = '{red: tt,    green: pp,    blue: vv6_q};
      default:       out_data_o = '{red: vv6_q, green: pp,    blue: qq};
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/hsv_chk.sv -----
// hsv_chk: port-level checks of the hsv to rgb converter, bound to the top level
`default_nettype none

module hsv_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire hsv_pkg::hsv_in_t  in_data_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire hsv_pkg::hsv_out_t out_data_o,
  input wire logic              out_stall_i
);
  import hsv_pkg::*;

  // a stalled output word stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // a stalled output word keeps its value
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // input only backs up behind a held output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("word present after reset");

endmodule

bind hsv_to_rgb_converter hsv_chk u_hsv_chk (.*);

`default_nettype wire
